// ===== rtl/prime_field_montgomery_alu_macros.svh =====
// Assertion shorthands for the modular ALU; all sample on clk and mute in reset.
`ifndef PRIME_FIELD_MONTGOMERY_ALU_MACROS_SVH
`define PRIME_FIELD_MONTGOMERY_ALU_MACROS_SVH

// Condition must hold at every edge.
`define PFM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PFM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pfm_pkg.sv =====
`default_nettype none

package pfm_pkg;

  localparam int LIMB_W    = 64;
  localparam int MAX_LIMBS = 8;
  localparam int IDX_W     = $clog2(MAX_LIMBS);

  typedef logic [LIMB_W-1:0] limb_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_POW = 3'd3;
  localparam logic [2:0] OP_INV = 3'd4;

  localparam limb_t TOP_P0 = 64'h04FF_FFFF_FFFF_FFFF;
  localparam limb_t TOP_P1 = 64'h40FF_FFFF_FFFF_FFFF;
  localparam limb_t TOP_P2 = 64'h1AFF_FFFF_FFFF_FFFF;

  // Index of the top limb; the reserved select code acts as the 8-limb prime.
  function automatic idx_t n_minus1(input logic [1:0] sel);
    idx_t r;
    case (sel)
      2'd0:    r = idx_t'(3);
      2'd1:    r = idx_t'(5);
      default: r = idx_t'(7);
    endcase
    return r;
  endfunction

  // Modulus limb: all ones below the top limb.
  function automatic limb_t mod_limb(input logic [1:0] sel, input idx_t idx);
    limb_t top;
    case (sel)
      2'd0:    top = TOP_P0;
      2'd1:    top = TOP_P1;
      default: top = TOP_P2;
    endcase
    return (idx == n_minus1(sel)) ? top : '1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/prime_field_montgomery_alu.sv =====
`default_nettype none
// Modular ALU over p = k*2^e-1 with 4, 6 or 8 64-bit limbs (cfg_prime_select).
// Input channel (in_valid / in_stall): one transaction per limb, least significant
// first; in_req_type is taken from the first limb. The last limb starts the op.
// Output channel (out_valid / out_stall): one transaction per result limb, least
// significant first, out_last_limb on the final one. An unknown opcode gives one
// transaction with zero data, last set and out_status set.
// Config channel (cfg_valid / cfg_ready): write while idle; drops a partial load.
// A raised cfg_valid stalls the input channel, so a limb never races a write.
// Add and subtract pass over the limbs twice. A Montgomery product runs
// 2n^2 limb products, each on the one shared 32x32 multiplier (four partial
// products), plus per-row overhead and a final subtraction. Power and inverse run
// one square per exponent bit below the top set bit and one more product per set
// bit, so up to ~128n products. Each result limb is read from the result memory
// once the output register is empty, then registered in it.
// The operand, accumulator and result stores are single-port-read memories with
// registered read data; read data of an entry is never used in the cycle it is written.
// The output register frees the sequencer: once the last limb is in it, a new
// load starts while the receiver still stalls. Sync reset returns to the load
// state with select 0 and an empty output register; memories are not cleared.
module prime_field_montgomery_alu (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  [2:0]            in_req_type,
  input  wire  [63:0]           in_a_limb,
  input  wire  [63:0]           in_b_limb,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [63:0]           out_result_limb,
  output logic                  out_last_limb,
  output logic                  out_status,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [1:0]            cfg_prime_select
);

  localparam logic [4:0] S_LOAD    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_ERR     = 5'd2;
  localparam logic [4:0] S_LP_RD   = 5'd3;
  localparam logic [4:0] S_LP_EX   = 5'd4;
  localparam logic [4:0] S_CP_RD   = 5'd5;
  localparam logic [4:0] S_CP_WR   = 5'd6;
  localparam logic [4:0] S_PW_RD   = 5'd7;
  localparam logic [4:0] S_PW_LD   = 5'd8;
  localparam logic [4:0] S_PW_BIT  = 5'd9;
  localparam logic [4:0] S_PW_SQ   = 5'd10;
  localparam logic [4:0] S_PW_NX   = 5'd11;
  localparam logic [4:0] S_MM_INIT = 5'd12;
  localparam logic [4:0] S_MM_X    = 5'd13;
  localparam logic [4:0] S_MM_XL   = 5'd14;
  localparam logic [4:0] S_MM_RD   = 5'd15;
  localparam logic [4:0] S_MM_OP   = 5'd16;
  localparam logic [4:0] S_MM_MUL  = 5'd17;
  localparam logic [4:0] S_MM_ACC  = 5'd18;
  localparam logic [4:0] S_MM_T1   = 5'd19;
  localparam logic [4:0] S_MM_M    = 5'd20;
  localparam logic [4:0] S_MM_ML   = 5'd21;
  localparam logic [4:0] S_MM_T2   = 5'd22;
  localparam logic [4:0] S_OUT_RD  = 5'd23;
  localparam logic [4:0] S_OUT_WR  = 5'd24;

  // limb pass kinds
  localparam logic [1:0] LP_ADD = 2'd0;
  localparam logic [1:0] LP_SUB = 2'd1;
  localparam logic [1:0] LP_FIN = 2'd2;

  // product operand sources
  localparam logic [1:0] SRC_A = 2'd0;
  localparam logic [1:0] SRC_B = 2'd1;
  localparam logic [1:0] SRC_R = 2'd2;

  localparam int MLW = pfm_pkg::LIMB_W;
  localparam int HW  = MLW / 2;

  // memories
  pfm_pkg::limb_t a_mem [pfm_pkg::MAX_LIMBS];
  pfm_pkg::limb_t b_mem [pfm_pkg::MAX_LIMBS];
  pfm_pkg::limb_t t_mem [pfm_pkg::MAX_LIMBS];
  pfm_pkg::limb_t r_mem [pfm_pkg::MAX_LIMBS];
  pfm_pkg::limb_t a_rd_r, b_rd_r, t_rd_r, r_rd_r;

  // control
  logic [4:0]        state_r, ret_r;
  logic [1:0]        sel_r;
  pfm_pkg::idx_t     cnt_r, i_r, j_r;
  logic [2:0]        op_r;
  logic [1:0]        lp_kind_r, x_src_r, y_src_r;
  logic              p2_r, c_r, bw_r, fin_c_r, fin_b_r;
  logic              first_r, red_r, inv_r, found_r, zero_r;
  logic [2:0]        q_r;
  logic [pfm_pkg::IDX_W+5:0] k_r;

  // datapath
  pfm_pkg::limb_t    xi_r, m_r, mb_r, t_hold_r, carry_r, tn_r, e_r;
  logic              tn1_r;
  logic [HW*2-1:0]   pp_r;
  logic [2*MLW-1:0]  prod_r;

  logic              out_valid_r, out_last_r, out_status_r;
  pfm_pkg::limb_t    out_limb_r;

  pfm_pkg::idx_t     n_m1, rd_addr;
  pfm_pkg::limb_t    mod_j, lp_x, sub_src, sub_sub, ma;
  logic [MLW:0]      add_sum, sub_res, fix_sum, tail;
  logic [MLW+1:0]    acc;
  pfm_pkg::limb_t    carry_nxt, lp_wdata;
  logic [HW-1:0]     pa, pb;
  logic [2*MLW-1:0]  pp_sh;
  logic              in_acc, cfg_acc, pw_bit;
  logic              t_we, r_we;
  pfm_pkg::idx_t     t_waddr;
  pfm_pkg::limb_t    t_wdata, r_wdata;

  // hold off limbs while busy or while a select write is offered
  assign in_stall        = (state_r != S_LOAD) || cfg_valid;
  assign cfg_ready       = (state_r == S_LOAD);
  assign out_valid       = out_valid_r;
  assign out_result_limb = out_limb_r;
  assign out_last_limb   = out_last_r;
  assign out_status      = out_status_r;

  assign in_acc  = in_valid && !in_stall;
  assign cfg_acc = cfg_valid && cfg_ready;
  assign n_m1    = pfm_pkg::n_minus1(sel_r);
  assign mod_j   = pfm_pkg::mod_limb(sel_r, j_r);
  assign pw_bit  = e_r[k_r[5:0]];

  // one shared read address for every memory
  always_comb begin
    case (state_r)
      S_MM_X:  rd_addr = i_r;
      S_MM_M:  rd_addr = '0;
      S_PW_RD: rd_addr = k_r[pfm_pkg::IDX_W+5:6];
      default: rd_addr = j_r;
    endcase
  end

  // limb passes: add/sub chains and the final Montgomery subtraction
  always_comb begin
    lp_x    = (lp_kind_r == LP_FIN) ? t_rd_r : a_rd_r;
    add_sum = {1'b0, a_rd_r} + {1'b0, b_rd_r} + {{MLW{1'b0}}, c_r};
    sub_src = (lp_kind_r == LP_ADD) ? add_sum[MLW-1:0] : lp_x;
    sub_sub = (lp_kind_r == LP_SUB) ? b_rd_r : mod_j;
    sub_res = {1'b0, sub_src} - {1'b0, sub_sub} - {{MLW{1'b0}}, bw_r};
    fix_sum = {1'b0, sub_res[MLW-1:0]} + {1'b0, mod_j} + {{MLW{1'b0}}, c_r};
    case (lp_kind_r)
      LP_ADD:  lp_wdata = (fin_c_r || !fin_b_r) ? sub_res[MLW-1:0] : add_sum[MLW-1:0];
      LP_SUB:  lp_wdata = fin_b_r ? fix_sum[MLW-1:0] : sub_res[MLW-1:0];
      default: lp_wdata = (!fin_b_r || tn_r != '0) ? sub_res[MLW-1:0] : t_rd_r;
    endcase
  end

  // multiply-accumulate step and partial products
  always_comb begin
    acc       = {2'b0, t_hold_r} + {2'b0, prod_r[MLW-1:0]} + {2'b0, carry_r};
    carry_nxt = prod_r[2*MLW-1:MLW] + {{(MLW-2){1'b0}}, acc[MLW+1:MLW]};
    tail      = {1'b0, tn_r} + {1'b0, carry_r};
    ma        = red_r ? m_r : xi_r;
    case (q_r[1:0])
      2'd0:    begin pa = ma[HW-1:0];   pb = mb_r[HW-1:0];   end
      2'd1:    begin pa = ma[HW-1:0];   pb = mb_r[MLW-1:HW]; end
      2'd2:    begin pa = ma[MLW-1:HW]; pb = mb_r[HW-1:0];   end
      default: begin pa = ma[MLW-1:HW]; pb = mb_r[MLW-1:HW]; end
    endcase
    case (q_r)
      3'd1:      pp_sh = {{MLW{1'b0}}, pp_r};
      3'd2, 3'd3: pp_sh = {{HW{1'b0}}, pp_r, {HW{1'b0}}};
      3'd4:      pp_sh = {pp_r, {MLW{1'b0}}};
      default:   pp_sh = '0;
    endcase
  end

  // accumulator and result memory write ports
  always_comb begin
    t_we    = ((state_r == S_MM_ACC) && (!red_r || j_r != '0)) || (state_r == S_MM_T2);
    t_waddr = (state_r == S_MM_T2) ? n_m1 : (red_r ? j_r - 1'b1 : j_r);
    t_wdata = (state_r == S_MM_T2) ? tail[MLW-1:0] : acc[MLW-1:0];
    r_we    = ((state_r == S_LP_EX) && p2_r) || (state_r == S_CP_WR);
    r_wdata = (state_r == S_CP_WR) ? a_rd_r : lp_wdata;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_mem[cnt_r] <= in_a_limb;
      b_mem[cnt_r] <= in_b_limb;
    end
    if (t_we) begin
      t_mem[t_waddr] <= t_wdata;
    end
    if (r_we) begin
      r_mem[j_r] <= r_wdata;
    end
    a_rd_r <= a_mem[rd_addr];
    b_rd_r <= b_mem[rd_addr];
    t_rd_r <= t_mem[rd_addr];
    r_rd_r <= r_mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      ret_r       <= S_OUT_RD;
      sel_r       <= '0;
      cnt_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      op_r        <= pfm_pkg::OP_ADD;
      lp_kind_r   <= LP_ADD;
      x_src_r     <= SRC_A;
      y_src_r     <= SRC_B;
      p2_r        <= 1'b0;
      c_r         <= 1'b0;
      bw_r        <= 1'b0;
      fin_c_r     <= 1'b0;
      fin_b_r     <= 1'b0;
      first_r     <= 1'b0;
      red_r       <= 1'b0;
      inv_r       <= 1'b0;
      found_r     <= 1'b0;
      zero_r      <= 1'b0;
      q_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the held result once taken
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (cfg_acc) begin
            sel_r <= cfg_prime_select;
            cnt_r <= '0;
          end else if (in_acc) begin
            if (cnt_r == '0) begin
              op_r <= in_req_type;
            end
            if (cnt_r == n_m1) begin
              cnt_r   <= '0;
              state_r <= S_DISP;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        S_DISP: begin
          found_r <= 1'b0;
          zero_r  <= 1'b0;
          j_r     <= '0;
          c_r     <= 1'b0;
          bw_r    <= 1'b0;
          p2_r    <= 1'b0;
          ret_r   <= S_OUT_RD;
          case (op_r)
            pfm_pkg::OP_ADD: begin
              lp_kind_r <= LP_ADD;
              state_r   <= S_LP_RD;
            end
            pfm_pkg::OP_SUB: begin
              lp_kind_r <= LP_SUB;
              state_r   <= S_LP_RD;
            end
            pfm_pkg::OP_MUL: begin
              x_src_r <= SRC_A;
              y_src_r <= SRC_B;
              state_r <= S_MM_INIT;
            end
            pfm_pkg::OP_POW, pfm_pkg::OP_INV: begin
              inv_r   <= (op_r == pfm_pkg::OP_INV);
              k_r     <= {n_m1, 6'h3F};
              state_r <= S_PW_RD;
            end
            default: state_r <= S_ERR;
          endcase
        end
        S_ERR: begin
          if (!out_valid_r) begin
            out_valid_r  <= 1'b1;
            out_limb_r   <= '0;
            out_last_r   <= 1'b1;
            out_status_r <= 1'b1;
            state_r      <= S_LOAD;
          end
        end
        S_LP_RD: state_r <= S_LP_EX;
        S_LP_EX: begin
          if (j_r == n_m1 && !p2_r) begin
            // restart both chains for the write pass
            c_r  <= 1'b0;
            bw_r <= 1'b0;
          end else begin
            bw_r <= sub_res[MLW];
            if (lp_kind_r == LP_ADD) begin
              c_r <= add_sum[MLW];
            end else if (lp_kind_r == LP_SUB && p2_r) begin
              c_r <= fix_sum[MLW];
            end else begin
              c_r <= 1'b0;
            end
          end
          if (j_r == n_m1) begin
            j_r <= '0;
            if (!p2_r) begin
              fin_c_r <= add_sum[MLW] && (lp_kind_r == LP_ADD);
              fin_b_r <= sub_res[MLW];
              p2_r    <= 1'b1;
              state_r <= S_LP_RD;
            end else begin
              state_r <= ret_r;
            end
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_LP_RD;
          end
        end
        S_CP_RD: state_r <= S_CP_WR;
        S_CP_WR: begin
          if (j_r == n_m1) begin
            j_r     <= '0;
            state_r <= S_PW_NX;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_CP_RD;
          end
        end
        S_PW_RD: state_r <= S_PW_LD;
        S_PW_LD: begin
          if (inv_r) begin
            e_r <= pfm_pkg::mod_limb(sel_r, k_r[pfm_pkg::IDX_W+5:6]) -
                   ((k_r[pfm_pkg::IDX_W+5:6] == '0) ? MLW'(2) : '0);
          end else begin
            e_r <= b_rd_r;
          end
          state_r <= S_PW_BIT;
        end
        S_PW_BIT: begin
          if (!found_r) begin
            if (pw_bit) begin
              found_r <= 1'b1;
              j_r     <= '0;
              state_r <= S_CP_RD;
            end else begin
              state_r <= S_PW_NX;
            end
          end else begin
            x_src_r <= SRC_R;
            y_src_r <= SRC_R;
            ret_r   <= S_PW_SQ;
            state_r <= S_MM_INIT;
          end
        end
        S_PW_SQ: begin
          if (pw_bit) begin
            x_src_r <= SRC_R;
            y_src_r <= SRC_A;
            ret_r   <= S_PW_NX;
            state_r <= S_MM_INIT;
          end else begin
            state_r <= S_PW_NX;
          end
        end
        S_PW_NX: begin
          if (k_r == '0) begin
            zero_r  <= !found_r;
            j_r     <= '0;
            state_r <= S_OUT_RD;
          end else begin
            k_r     <= k_r - 1'b1;
            state_r <= (k_r[5:0] == 6'd0) ? S_PW_RD : S_PW_BIT;
          end
        end
        S_MM_INIT: begin
          i_r     <= '0;
          first_r <= 1'b1;
          tn_r    <= '0;
          tn1_r   <= 1'b0;
          state_r <= S_MM_X;
        end
        S_MM_X: state_r <= S_MM_XL;
        S_MM_XL: begin
          xi_r    <= (x_src_r == SRC_A) ? a_rd_r : r_rd_r;
          red_r   <= 1'b0;
          j_r     <= '0;
          carry_r <= '0;
          state_r <= S_MM_RD;
        end
        S_MM_RD: state_r <= S_MM_OP;
        S_MM_OP: begin
          if (red_r) begin
            mb_r <= mod_j;
          end else begin
            case (y_src_r)
              SRC_A:   mb_r <= a_rd_r;
              SRC_B:   mb_r <= b_rd_r;
              default: mb_r <= r_rd_r;
            endcase
          end
          t_hold_r <= (first_r && !red_r) ? '0 : t_rd_r;
          prod_r   <= '0;
          q_r      <= '0;
          state_r  <= S_MM_MUL;
        end
        S_MM_MUL: begin
          // one partial product a cycle, summed in the cycle after
          pp_r   <= pa * pb;
          prod_r <= prod_r + pp_sh;
          if (q_r == 3'd4) begin
            state_r <= S_MM_ACC;
          end else begin
            q_r <= q_r + 1'b1;
          end
        end
        S_MM_ACC: begin
          carry_r <= carry_nxt;
          if (j_r == n_m1) begin
            state_r <= red_r ? S_MM_T2 : S_MM_T1;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_MM_RD;
          end
        end
        S_MM_T1: begin
          tn_r    <= tail[MLW-1:0];
          tn1_r   <= tail[MLW];
          state_r <= S_MM_M;
        end
        S_MM_M: state_r <= S_MM_ML;
        S_MM_ML: begin
          m_r     <= t_rd_r;
          red_r   <= 1'b1;
          j_r     <= '0;
          carry_r <= '0;
          state_r <= S_MM_RD;
        end
        S_MM_T2: begin
          tn_r    <= {{(MLW-1){1'b0}}, tn1_r} + {{(MLW-1){1'b0}}, tail[MLW]};
          tn1_r   <= 1'b0;
          first_r <= 1'b0;
          if (i_r == n_m1) begin
            lp_kind_r <= LP_FIN;
            p2_r      <= 1'b0;
            j_r       <= '0;
            c_r       <= 1'b0;
            bw_r      <= 1'b0;
            state_r   <= S_LP_RD;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_MM_X;
          end
        end
        S_OUT_RD: begin
          if (!out_valid_r) begin
            state_r <= S_OUT_WR;
          end
        end
        S_OUT_WR: begin
          out_valid_r  <= 1'b1;
          out_limb_r   <= zero_r ? '0 : r_rd_r;
          out_last_r   <= (j_r == n_m1);
          out_status_r <= 1'b0;
          if (j_r == n_m1) begin
            j_r     <= '0;
            state_r <= S_LOAD;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_OUT_RD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

`include "prime_field_montgomery_alu_macros.svh"

  `PFM_ASSERT_IMPLY(a_err_is_last, out_valid && out_status, out_last_limb, "error result not last")
  `PFM_ASSERT_ALWAYS(a_cnt_range, cnt_r <= n_m1, "load count beyond limb count")
  `PFM_ASSERT_IMPLY(a_idx_range, state_r != S_LOAD, j_r <= n_m1, "limb index beyond limb count")
  `PFM_ASSERT_NEXT(a_out_done, (state_r == S_OUT_WR) && (j_r == n_m1), state_r == S_LOAD, "no return to load after last limb")

endmodule

`default_nettype wire

// ===== sim/pfm_checker.sv =====
`timescale 1ns / 1ps

// Watches the limb, result and select channels, keeps a modular arithmetic
// predictor of the ALU and compares each result limb with the oldest prediction.
module pfm_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire  [2:0]  in_req_type,
  input  wire  [63:0] in_a_limb,
  input  wire  [63:0] in_b_limb,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire  [63:0] out_result_limb,
  input  wire         out_last_limb,
  input  wire         out_status,
  input  wire         cfg_valid,
  input  wire         cfg_ready,
  input  wire  [1:0]  cfg_prime_select,
  output int          fail_count,
  output int          pending_limbs
);

  typedef pfm_pkg::limb_t vec_t [pfm_pkg::MAX_LIMBS];

  typedef struct packed {
    pfm_pkg::limb_t data;
    logic  last;
    logic  status;
  } beat_t;

  beat_t  result_q[$];
  logic [1:0] sel_q;
  int     load_idx;
  logic [2:0] op_q;
  vec_t   a_st, b_st;

  function automatic int limb_total(input logic [1:0] sel);
    return (sel == 2'd0) ? 4 : (sel == 2'd1) ? 6 : 8;
  endfunction

  function automatic void modulus_of(input logic [1:0] sel, output vec_t m);
    int n;
    n = limb_total(sel);
    for (int i = 0; i < pfm_pkg::MAX_LIMBS; i++) m[i] = (i < n) ? '1 : '0;
    m[n-1] = (sel == 2'd0) ? pfm_pkg::TOP_P0 :
             (sel == 2'd1) ? pfm_pkg::TOP_P1 : pfm_pkg::TOP_P2;
  endfunction

  function automatic void mod_add(input vec_t x, input vec_t y, input vec_t m, input int n,
                                  output vec_t r);
    vec_t sum, red;
    logic [64:0] s;
    logic c, bw;
    c = 0;
    bw = 0;
    r = x;
    for (int i = 0; i < n; i++) begin
      s = 65'(x[i]) + 65'(y[i]) + 65'(c);
      sum[i] = s[63:0];
      c = s[64];
    end
    for (int i = 0; i < n; i++) begin
      s = 65'(sum[i]) - 65'(m[i]) - 65'(bw);
      red[i] = s[63:0];
      bw = s[64];
    end
    for (int i = 0; i < n; i++) r[i] = (c || !bw) ? red[i] : sum[i];
  endfunction

  function automatic void mod_sub(input vec_t x, input vec_t y, input vec_t m, input int n,
                                  output vec_t r);
    logic [64:0] s;
    logic c, bw;
    c = 0;
    bw = 0;
    r = x;
    for (int i = 0; i < n; i++) begin
      s = 65'(x[i]) - 65'(y[i]) - 65'(bw);
      r[i] = s[63:0];
      bw = s[64];
    end
    if (bw) begin
      for (int i = 0; i < n; i++) begin
        s = 65'(r[i]) + 65'(m[i]) + 65'(c);
        r[i] = s[63:0];
        c = s[64];
      end
    end
  endfunction

  // Operand-scanning Montgomery product, mu = 1; keeps the overflow word.
  function automatic void mont_prod(input vec_t x, input vec_t y, input vec_t m, input int n,
                                    output vec_t r);
    pfm_pkg::limb_t t [pfm_pkg::MAX_LIMBS+2];
    vec_t dif;
    logic [127:0] acc;
    logic [64:0] s;
    pfm_pkg::limb_t carry, q;
    logic bw;
    for (int i = 0; i < pfm_pkg::MAX_LIMBS + 2; i++) t[i] = '0;
    r = x;
    for (int i = 0; i < n; i++) begin
      carry = '0;
      for (int j = 0; j < n; j++) begin
        acc = 128'(x[i]) * 128'(y[j]) + 128'(t[j]) + 128'(carry);
        t[j] = acc[63:0];
        carry = acc[127:64];
      end
      s = 65'(t[n]) + 65'(carry);
      t[n] = s[63:0];
      t[n+1] = pfm_pkg::limb_t'(s[64]);
      q = t[0];
      acc = 128'(q) * 128'(m[0]) + 128'(t[0]);
      carry = acc[127:64];
      for (int j = 1; j < n; j++) begin
        acc = 128'(q) * 128'(m[j]) + 128'(t[j]) + 128'(carry);
        t[j-1] = acc[63:0];
        carry = acc[127:64];
      end
      s = 65'(t[n]) + 65'(carry);
      t[n-1] = s[63:0];
      t[n] = t[n+1] + pfm_pkg::limb_t'(s[64]);
      t[n+1] = '0;
    end
    bw = 0;
    for (int i = 0; i < n; i++) begin
      s = 65'(t[i]) - 65'(m[i]) - 65'(bw);
      dif[i] = s[63:0];
      bw = s[64];
    end
    for (int i = 0; i < n; i++) r[i] = (!bw || t[n] != '0) ? dif[i] : t[i];
  endfunction

  function automatic void mod_pow(input vec_t base, input vec_t e, input vec_t m, input int n,
                                  output vec_t r);
    int top;
    vec_t tmp;
    top = n * 64 - 1;
    while (top >= 0 && !e[top/64][top%64]) top--;
    for (int i = 0; i < pfm_pkg::MAX_LIMBS; i++) r[i] = '0;
    if (top >= 0) begin
      r = base;
      for (int k = top - 1; k >= 0; k--) begin
        mont_prod(r, r, m, n, tmp);
        r = tmp;
        if (e[k/64][k%64]) begin
          mont_prod(r, base, m, n, tmp);
          r = tmp;
        end
      end
    end
  endfunction

  function automatic void predict_op();
    vec_t m, res, e;
    int n;
    beat_t bt;
    n = limb_total(sel_q);
    modulus_of(sel_q, m);
    case (op_q)
      pfm_pkg::OP_ADD: mod_add(a_st, b_st, m, n, res);
      pfm_pkg::OP_SUB: mod_sub(a_st, b_st, m, n, res);
      pfm_pkg::OP_MUL: mont_prod(a_st, b_st, m, n, res);
      pfm_pkg::OP_POW: mod_pow(a_st, b_st, m, n, res);
      pfm_pkg::OP_INV: begin
        e = m;
        e[0] = e[0] - 64'd2;
        mod_pow(a_st, e, m, n, res);
      end
      default: begin
        bt = '{data: '0, last: 1'b1, status: 1'b1};
        result_q.push_back(bt);
        return;
      end
    endcase
    for (int k = 0; k < n; k++) begin
      bt = '{data: res[k], last: (k == n - 1), status: 1'b0};
      result_q.push_back(bt);
    end
  endfunction

  always @(posedge clk) begin
    beat_t want;
    if (!rst_n) begin
      sel_q <= 2'd0;
      load_idx = 0;
      op_q = pfm_pkg::OP_ADD;
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: unexpected result limb %h last %b status %b",
                     out_result_limb, out_last_limb, out_status);
          fail_count <= fail_count + 1;
        end else begin
          want = result_q.pop_front();
          if (want.data !== out_result_limb || want.last !== out_last_limb ||
              want.status !== out_status) begin
            if (fail_count < 10)
              $display("ERROR: result limb exp %h/%b/%b got %h/%b/%b", want.data,
                       want.last, want.status, out_result_limb, out_last_limb, out_status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        sel_q <= cfg_prime_select;
        load_idx = 0;
      end else if (in_valid && !in_stall) begin
        if (load_idx == 0) op_q = in_req_type;
        a_st[load_idx] = in_a_limb;
        b_st[load_idx] = in_b_limb;
        if (load_idx + 1 < limb_total(sel_q)) begin
          load_idx = load_idx + 1;
        end else begin
          load_idx = 0;
          predict_op();
        end
      end
    end
    pending_limbs <= result_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  // Reserved opcodes: the block answers them with one error transaction.
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;
  localparam int WATCHDOG_LIMIT = 2_000_000;
  localparam int RANDOM_LIMBS   = 200;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  in_req_type = '0;
  logic [63:0] in_a_limb = '0;
  logic [63:0] in_b_limb = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [63:0] out_result_limb;
  logic        out_last_limb;
  logic        out_status;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_prime_select = '0;

  int   fail_count;
  int   pending_limbs;
  logic in_taken, cfg_taken;
  logic [1:0] cur_sel;
  int   stall_left;
  logic stall_quiet;
  int   idle_cycles;
  int   inv_budget;

  always #5 clk = ~clk;

  prime_field_montgomery_alu i_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_req_type, .in_a_limb, .in_b_limb,
    .out_valid, .out_stall, .out_result_limb, .out_last_limb, .out_status,
    .cfg_valid, .cfg_ready, .cfg_prime_select
  );

  pfm_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_req_type, .in_a_limb, .in_b_limb,
    .out_valid, .out_stall, .out_result_limb, .out_last_limb, .out_status,
    .cfg_valid, .cfg_ready, .cfg_prime_select,
    .fail_count, .pending_limbs
  );

  // Capture handshakes with pre-edge values; the driver looks at them on the
  // following falling edge.
  always @(posedge clk) begin
    in_taken  <= in_valid && !in_stall;
    cfg_taken <= cfg_valid && cfg_ready;
  end

  // Watchdog: end the run if no transaction moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL prime_field_montgomery_alu");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver back-pressure: mostly short stalls, a few long ones, and quiet
  // stretches where it never stalls.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
      if ($urandom_range(0, 199) == 0) stall_quiet = !stall_quiet;
      if (!stall_quiet) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5: stall_left = $urandom_range(1, 3);
          6:                stall_left = $urandom_range(20, 80);
          default:          stall_left = 0;
        endcase
        out_stall = (stall_left > 0);
      end
    end
  end

  function automatic int limbs_for(input logic [1:0] sel);
    return (sel == 2'd0) ? 4 : (sel == 2'd1) ? 6 : 8;
  endfunction

  function automatic pfm_pkg::limb_t top_of(input logic [1:0] sel);
    return (sel == 2'd0) ? pfm_pkg::TOP_P0 :
           (sel == 2'd1) ? pfm_pkg::TOP_P1 : pfm_pkg::TOP_P2;
  endfunction

  function automatic pfm_pkg::limb_t rand64();
    return {$urandom, $urandom};
  endfunction

  // Sender gap: mostly none, sometimes a short pause, rarely a long one.
  task automatic sender_gap();
    int g;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: g = $urandom_range(1, 3);
      4:          g = $urandom_range(15, 60);
      default:    g = 0;
    endcase
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Present one limb and hold it until accepted; valid stays up for the next.
  task automatic push_limb(input logic [2:0] op, input pfm_pkg::limb_t a,
                           input pfm_pkg::limb_t b);
    sender_gap();
    in_valid    = 1'b1;
    in_req_type = op;
    in_a_limb   = a;
    in_b_limb   = b;
    do @(negedge clk); while (!in_taken);
  endtask

  // Hold off until every predicted result limb has drained, then settle.
  task automatic drain();
    in_valid = 1'b0;
    while (pending_limbs != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_select(input logic [1:0] sel);
    drain();
    cfg_valid        = 1'b1;
    cfg_prime_select = sel;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid = 1'b0;
    cur_sel   = sel;
  endtask

  // Send a full operation. Exponent limbs are passed in b; the request type
  // rides on every limb but only the first counts.
  task automatic send_op(input logic [2:0] op, input pfm_pkg::limb_t a [pfm_pkg::MAX_LIMBS],
                         input pfm_pkg::limb_t b [pfm_pkg::MAX_LIMBS]);
    for (int i = 0; i < limbs_for(cur_sel); i++) push_limb(op, a[i], b[i]);
  endtask

  // Random operand: usually below p, sometimes raw bits or all ones.
  task automatic rand_operand(output pfm_pkg::limb_t v [pfm_pkg::MAX_LIMBS]);
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    n = limbs_for(cur_sel);
    for (int i = 0; i < pfm_pkg::MAX_LIMBS; i++) v[i] = rand64();
    if (kind == 0) begin
      for (int i = 0; i < pfm_pkg::MAX_LIMBS; i++) v[i] = '1;
    end else if (kind <= 7) begin
      v[n-1] = rand64() % top_of(cur_sel);
    end
  endtask

  task automatic random_op();
    pfm_pkg::limb_t a [pfm_pkg::MAX_LIMBS];
    pfm_pkg::limb_t b [pfm_pkg::MAX_LIMBS];
    logic [2:0] op;
    int pick;
    rand_operand(a);
    rand_operand(b);
    pick = $urandom_range(0, 19);
    if (pick < 5) op = pfm_pkg::OP_ADD;
    else if (pick < 10) op = pfm_pkg::OP_SUB;
    else if (pick < 15) op = pfm_pkg::OP_MUL;
    else if (pick < 18) op = pfm_pkg::OP_POW;
    else if (pick < 19 && cur_sel == 2'd0 && inv_budget > 0) op = pfm_pkg::OP_INV;
    else op = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
    if (op == pfm_pkg::OP_INV) inv_budget--;
    if (op == pfm_pkg::OP_POW) begin
      // Keep the exponent short so the run stays bounded; zero now and then.
      for (int i = 0; i < pfm_pkg::MAX_LIMBS; i++) b[i] = '0;
      if ($urandom_range(0, 7) != 0) b[0] = 64'($urandom_range(1, 4095));
    end
    send_op(op, a, b);
  endtask

  initial begin
    pfm_pkg::limb_t a [pfm_pkg::MAX_LIMBS];
    pfm_pkg::limb_t b [pfm_pkg::MAX_LIMBS];
    int sent;
    logic [1:0] next_sel;
    stall_left  = 0;
    stall_quiet = 0;
    idle_cycles = 0;
    inv_budget  = 2;
    cur_sel     = 2'd0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: p-1 + p-1, 0 - 1, all-ones product, zero exponent, inverse,
    // a reserved opcode, on the 4-limb prime.
    for (int i = 0; i < pfm_pkg::MAX_LIMBS; i++) begin
      a[i] = '1;
      b[i] = '1;
    end
    a[0] = 64'hFFFF_FFFF_FFFF_FFFE;
    a[3] = pfm_pkg::TOP_P0;
    b[0] = a[0];
    b[3] = pfm_pkg::TOP_P0;
    send_op(pfm_pkg::OP_ADD, a, b);
    for (int i = 0; i < pfm_pkg::MAX_LIMBS; i++) begin
      a[i] = '0;
      b[i] = '0;
    end
    b[0] = 64'd1;
    send_op(pfm_pkg::OP_SUB, a, b);
    for (int i = 0; i < pfm_pkg::MAX_LIMBS; i++) begin
      a[i] = '1;
      b[i] = '1;
    end
    send_op(pfm_pkg::OP_MUL, a, b);
    for (int i = 0; i < pfm_pkg::MAX_LIMBS; i++) b[i] = '0;
    send_op(pfm_pkg::OP_POW, a, b);
    for (int i = 0; i < pfm_pkg::MAX_LIMBS; i++) a[i] = '0;
    a[0] = 64'd3;
    send_op(pfm_pkg::OP_INV, a, b);
    send_op(OP_RSVD_HI, a, b);

    // Drop a partial load with a select write, including the reserved code.
    push_limb(pfm_pkg::OP_MUL, rand64(), rand64());
    push_limb(pfm_pkg::OP_MUL, rand64(), rand64());
    write_select(2'd3);
    random_op();

    // Random phases across all select values; every phase boundary drains.
    sent = 0;
    while (sent < RANDOM_LIMBS) begin
      next_sel = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 2) == 0) begin
        for (int i = $urandom_range(1, 3); i > 0; i--)
          push_limb(3'($urandom_range(0, 7)), rand64(), rand64());
      end
      write_select(next_sel);
      for (int k = $urandom_range(2, 6); k > 0; k--) begin
        random_op();
        sent += limbs_for(cur_sel);
      end
    end

    write_select(2'd0);
    drain();
    if (fail_count == 0) begin
      $display("PASS prime_field_montgomery_alu");
    end else begin
      $display("FAIL prime_field_montgomery_alu");
    end
    $finish;
  end

endmodule
